// ----- rtl/core/sbge_pkg.sv -----
`timescale 1ns / 1ps

package sbge_pkg;

    // Configuration port and register map.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 56;

    localparam logic [CFG_IDX_W-1:0] REG_BAND_ZERO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_ONE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_TWO  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_GAIN = 2'd3;

    localparam int SETUP_REGS = 3;
    localparam int BASE_W     = 17;

    // Field widths of one band setup word.
    localparam int IDX_W   = 11;
    localparam int POS_W   = 12;
    localparam int GAIN_W  = 18;
    localparam int KW_W    = 24;
    localparam int SQ_W    = 2 * POS_W;
    localparam int ARG_W   = SQ_W + KW_W;

    // The exp argument is Q.24; the table covers [0,8) at 32 steps per unit.
    localparam int EXP_ENTRIES = 256;
    localparam int EXP_W       = 16;
    localparam int ARG_LSB     = 19;
    localparam int ARG_MSB     = 26;

    // Envelope arithmetic, all in Q.16.
    localparam int TERM_W  = 20;
    localparam int ENV_W   = 22;
    localparam int ENV_U_W = 21;

    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_LOW  = 2'd1,
        MODE_HIGH = 2'd2,
        MODE_BAND = 2'd3
    } band_mode_t;

    typedef struct packed {
        band_mode_t               mode;
        logic [POS_W-1:0]         pos;
        logic signed [GAIN_W-1:0] gain;
        logic [KW_W-1:0]          width;
    } band_cfg_t;

    typedef logic [EXP_W-1:0] exp_tab_t [EXP_ENTRIES];

    // exp(-i/32) in Q0.16, built by repeated Q0.32 multiplication with a
    // series value of exp(-1/32). Entry zero saturates to all ones.
    function automatic exp_tab_t build_exp();
        exp_tab_t    tab;
        logic [63:0] term;
        logic [63:0] e1;
        logic [63:0] cur;
        logic [63:0] v;
        term = 64'd1 << 32;
        e1   = 64'd1 << 32;
        cur  = 64'd1 << 32;
        for (int n = 1; n <= 10; n++)
        begin
            term = term / 64'(32 * n);
            if ((n & 1) != 0)
            begin
                e1 = e1 - term;
            end
            else
            begin
                e1 = e1 + term;
            end
        end
        for (int i = 0; i < EXP_ENTRIES; i++)
        begin
            v      = (cur + 64'd32768) >> 16;
            tab[i] = (v > 64'd65535) ? 16'hFFFF : v[EXP_W-1:0];
            cur    = (cur * e1 + (64'd1 << 31)) >> 32;
        end
        return tab;
    endfunction

    localparam exp_tab_t EXP_TAB = build_exp();

endpackage

// ----- rtl/core/sbge_band_lane.sv -----
`timescale 1ns / 1ps

// One band's contribution to the envelope, four register stages deep.
module sbge_band_lane (
    input  logic                                   clk,
    input  sbge_pkg::band_cfg_t                    band_cfg,
    input  logic [3:0]                             stage_en,
    input  logic [sbge_pkg::IDX_W-1:0]             idx,
    output logic signed [sbge_pkg::TERM_W-1:0]     term
);

    logic [sbge_pkg::POS_W-1:0]          idx_ext;
    logic [sbge_pkg::POS_W-1:0]          span;
    logic signed [sbge_pkg::TERM_W-1:0]  step_gain;
    logic signed [sbge_pkg::TERM_W-1:0]  lh_next;
    logic [sbge_pkg::SQ_W-1:0]           sq_next;
    logic [sbge_pkg::SQ_W-1:0]           sq_reg;
    logic signed [sbge_pkg::TERM_W-1:0]  lh_a_reg;
    logic [sbge_pkg::ARG_W-1:0]          arg_reg;
    logic signed [sbge_pkg::TERM_W-1:0]  lh_b_reg;
    logic                                in_range;
    logic [sbge_pkg::EXP_W-1:0]          exp_next;
    logic [sbge_pkg::EXP_W-1:0]          exp_reg;
    logic signed [sbge_pkg::TERM_W-1:0]  lh_c_reg;
    logic signed [34:0]                  bp_prod;
    logic signed [34:0]                  bp_round;
    logic signed [sbge_pkg::TERM_W-1:0]  term_next;
    logic signed [sbge_pkg::TERM_W-1:0]  term_reg;

    // Distance to the position bin and the low/high step term.
    always_comb
    begin
        idx_ext   = sbge_pkg::POS_W'(idx);
        span      = (idx_ext >= band_cfg.pos) ? idx_ext - band_cfg.pos
                                              : band_cfg.pos - idx_ext;
        sq_next   = sbge_pkg::SQ_W'(span) * sbge_pkg::SQ_W'(span);
        step_gain = {band_cfg.gain, 2'b00};
        case (band_cfg.mode)
            sbge_pkg::MODE_NONE: lh_next = '0;
            sbge_pkg::MODE_LOW:  lh_next = (idx_ext < band_cfg.pos) ? step_gain : '0;
            sbge_pkg::MODE_HIGH: lh_next = (idx_ext > band_cfg.pos) ? step_gain : '0;
            sbge_pkg::MODE_BAND: lh_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            sq_reg   <= sq_next;
            lh_a_reg <= lh_next;
        end
        if (stage_en[1])
        begin
            arg_reg  <= sbge_pkg::ARG_W'(sq_reg) * sbge_pkg::ARG_W'(band_cfg.width);
            lh_b_reg <= lh_a_reg;
        end
        if (stage_en[2])
        begin
            exp_reg  <= exp_next;
            lh_c_reg <= lh_b_reg;
        end
        if (stage_en[3])
        begin
            term_reg <= term_next;
        end
    end

    // Arguments of eight and above fall off the table and give no term.
    always_comb
    begin
        in_range = (arg_reg[sbge_pkg::ARG_W-1:sbge_pkg::ARG_MSB+1] == '0);
        exp_next = in_range
                 ? sbge_pkg::EXP_TAB[arg_reg[sbge_pkg::ARG_MSB:sbge_pkg::ARG_LSB]]
                 : '0;
    end

    // Gain times table value, rounded half up from Q.30 to Q.16.
    always_comb
    begin
        bp_prod   = 35'($signed(band_cfg.gain)) * 35'($signed({1'b0, exp_reg}));
        bp_round  = bp_prod + 35'sd8192;
        term_next = (band_cfg.mode == sbge_pkg::MODE_BAND)
                  ? bp_round[14 +: sbge_pkg::TERM_W] : lh_c_reg;
    end

    assign term = term_reg;

endmodule

// ----- rtl/core/sbge_scale.sv -----
`timescale 1ns / 1ps

// Multiplies both parts by the envelope, then rounds and saturates.
module sbge_scale #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                clk,
    input  logic [1:0]                          stage_en,
    input  logic [sbge_pkg::IDX_W-1:0]          idx,
    input  logic signed [SAMPLE_BITS-1:0]       re,
    input  logic signed [SAMPLE_BITS-1:0]       im,
    input  logic [sbge_pkg::ENV_U_W-1:0]        env,
    output logic [sbge_pkg::IDX_W-1:0]          out_index,
    output logic signed [SAMPLE_BITS-1:0]       out_real,
    output logic signed [SAMPLE_BITS-1:0]       out_imag,
    output logic                                clipped
);

    localparam int PROD_W = SAMPLE_BITS + sbge_pkg::ENV_U_W + 1;
    localparam int RES_W  = PROD_W - 16;
    localparam logic signed [RES_W-1:0] SAT_HI =
        RES_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [RES_W-1:0] SAT_LO = -SAT_HI - RES_W'(1);

    logic signed [sbge_pkg::ENV_U_W:0]  env_s;
    logic signed [PROD_W-1:0]           prod_re_reg;
    logic signed [PROD_W-1:0]           prod_im_reg;
    logic [sbge_pkg::IDX_W-1:0]         idx_reg;
    logic [SAMPLE_BITS:0]               sat_re;
    logic [SAMPLE_BITS:0]               sat_im;
    logic [sbge_pkg::IDX_W-1:0]         out_index_reg;
    logic signed [SAMPLE_BITS-1:0]      out_real_reg;
    logic signed [SAMPLE_BITS-1:0]      out_imag_reg;
    logic                               clipped_reg;

    // Returns the clip flag above the saturated value.
    function automatic logic [SAMPLE_BITS:0] round_sat(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] rounded;
        logic signed [RES_W-1:0]  r;
        rounded = p + PROD_W'(32768);
        r       = rounded[PROD_W-1:16];
        if (r > SAT_HI)
        begin
            return {1'b1, SAT_HI[SAMPLE_BITS-1:0]};
        end
        if (r < SAT_LO)
        begin
            return {1'b1, SAT_LO[SAMPLE_BITS-1:0]};
        end
        return {1'b0, r[SAMPLE_BITS-1:0]};
    endfunction

    assign env_s = $signed({1'b0, env});

    always_comb
    begin
        sat_re = round_sat(prod_re_reg);
        sat_im = round_sat(prod_im_reg);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            prod_re_reg <= PROD_W'(re) * PROD_W'(env_s);
            prod_im_reg <= PROD_W'(im) * PROD_W'(env_s);
            idx_reg     <= idx;
        end
        if (stage_en[1])
        begin
            out_real_reg  <= sat_re[SAMPLE_BITS-1:0];
            out_imag_reg  <= sat_im[SAMPLE_BITS-1:0];
            clipped_reg   <= sat_re[SAMPLE_BITS] | sat_im[SAMPLE_BITS];
            out_index_reg <= idx_reg;
        end
    end

    assign out_index = out_index_reg;
    assign out_real  = out_real_reg;
    assign out_imag  = out_imag_reg;
    assign clipped   = clipped_reg;

endmodule

// ----- rtl/core/spectral_band_gain_equalizer_top.sv -----
`timescale 1ns / 1ps

// Spectral band gain equalizer: each complex FFT bin that enters is scaled
// by a real envelope gain built from a base level plus up to three bands
// (lowpass step, highpass step, or a Gaussian bandpass from an exp table),
// clamped at zero, and both parts are rounded and saturated to SAMPLE_BITS
// bits with a clipped flag. The block takes one bin per clock cycle while
// in_ready is high and presents the results at the output in order. The
// pipe has nine register stages: two for the index reduction, four in each
// band lane (distance square, width product, table lookup, gain product),
// one for the envelope sum and two for the part products with their
// rounding and saturation. Every stage holds its contents while the one
// after it is full and stalled, so a bubble in the pipe is closed up and an
// input transaction is still taken while a finished result waits at the
// output, as long as some stage is empty. The user writes band and base
// registers through the configuration port only while no transaction is in
// flight; the block itself does not enforce this. There is no read-back.

module spectral_band_gain_equalizer_top #(
    parameter int HALF_BINS   = 2048,
    parameter int BAND_COUNT  = 3,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_we,
    input  logic [sbge_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sbge_pkg::CFG_DATA_W-1:0]      cfg_data,

    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [sbge_pkg::IDX_W-1:0]           bin_index,
    input  logic signed [SAMPLE_BITS-1:0]        bin_real,
    input  logic signed [SAMPLE_BITS-1:0]        bin_imag,

    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [sbge_pkg::IDX_W-1:0]           out_index,
    output logic signed [SAMPLE_BITS-1:0]        out_real,
    output logic signed [SAMPLE_BITS-1:0]        out_imag,
    output logic                                 clipped
);

    // Bands past the three setup registers never contribute.
    localparam int NUM_LANES = (BAND_COUNT < sbge_pkg::SETUP_REGS)
                             ? BAND_COUNT : sbge_pkg::SETUP_REGS;
    localparam int STAGES    = 9;

    // The bin index is reduced modulo HALF_BINS with a reciprocal multiply;
    // the estimated quotient is at most one short, fixed by one subtract.
    localparam int RECIP   = 65536 / HALF_BINS;
    localparam int QPROD_W = 2 * sbge_pkg::IDX_W;
    localparam int QUO_W   = QPROD_W - 16;
    localparam int REM_W   = 20;

    localparam int ST_IDX  = 2;   // bin index reduced
    localparam int ST_LANE = 3;   // first of four band lane stages
    localparam int ST_ENV  = 7;   // envelope summed and clamped
    localparam int ST_MUL  = 8;   // part products

    logic [STAGES:1] valid_reg;
    logic [STAGES:1] stage_en;

    logic [sbge_pkg::CFG_DATA_W-1:0]    band_setup_reg [NUM_LANES];
    logic [sbge_pkg::BASE_W-1:0]        base_gain_reg;
    sbge_pkg::band_cfg_t                band_cfg [NUM_LANES];

    logic [QPROD_W-1:0]                 quo_prod;
    logic [QUO_W-1:0]                   s1_quo_reg;
    logic [sbge_pkg::IDX_W-1:0]         s1_idx_reg;
    logic signed [SAMPLE_BITS-1:0]      s1_re_reg;
    logic signed [SAMPLE_BITS-1:0]      s1_im_reg;

    logic [REM_W-1:0]                   rem_wide;
    logic [REM_W-1:0]                   rem_fixed;
    logic [sbge_pkg::IDX_W-1:0]         idx_next;

    logic [sbge_pkg::IDX_W-1:0]         idx_pipe_reg [ST_IDX:ST_ENV];
    logic signed [SAMPLE_BITS-1:0]      re_pipe_reg  [ST_IDX:ST_ENV];
    logic signed [SAMPLE_BITS-1:0]      im_pipe_reg  [ST_IDX:ST_ENV];

    logic signed [sbge_pkg::TERM_W-1:0] lane_term [NUM_LANES];
    logic signed [sbge_pkg::ENV_W-1:0]  env_sum;
    logic [sbge_pkg::ENV_U_W-1:0]       env_next;
    logic [sbge_pkg::ENV_U_W-1:0]       env_reg;

    // Handshake: a stage loads when it is empty or the stage after it moves.
    always_comb
    begin
        stage_en[STAGES] = !valid_reg[STAGES] || out_ready;
        for (int s = STAGES - 1; s >= 1; s--)
        begin
            stage_en[s] = !valid_reg[s] || stage_en[s + 1];
        end
    end

    assign in_ready  = stage_en[1];
    assign out_valid = valid_reg[STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_en[1])
            begin
                valid_reg[1] <= in_valid;
            end
            for (int s = 2; s <= STAGES; s++)
            begin
                if (stage_en[s])
                begin
                    valid_reg[s] <= valid_reg[s - 1];
                end
            end
        end
    end

    // Configuration registers. Writes to a band that is not built are dropped.
    for (genvar l = 0; l < NUM_LANES; l++)
    begin : g_setup
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                band_setup_reg[l] <= '0;
            end
            else if (cfg_we && (cfg_index == sbge_pkg::REG_BAND_ZERO
                                + sbge_pkg::CFG_IDX_W'(l)))
            begin
                band_setup_reg[l] <= cfg_data;
            end
        end

        always_comb
        begin
            band_cfg[l].mode  = sbge_pkg::band_mode_t'(band_setup_reg[l][1:0]);
            band_cfg[l].pos   = band_setup_reg[l][13:2];
            band_cfg[l].gain  = band_setup_reg[l][31:14];
            band_cfg[l].width = band_setup_reg[l][55:32];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_gain_reg <= '0;
        end
        else if (cfg_we && (cfg_index == sbge_pkg::REG_BASE_GAIN))
        begin
            base_gain_reg <= cfg_data[sbge_pkg::BASE_W-1:0];
        end
    end

    // Stage 1: quotient estimate. Stage 2: remainder with correction.
    assign quo_prod = QPROD_W'(bin_index) * QPROD_W'(RECIP);

    always_comb
    begin
        rem_wide  = REM_W'(s1_idx_reg) - REM_W'(s1_quo_reg) * REM_W'(HALF_BINS);
        rem_fixed = (rem_wide >= REM_W'(HALF_BINS)) ? rem_wide - REM_W'(HALF_BINS)
                                                    : rem_wide;
        idx_next  = rem_fixed[sbge_pkg::IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            s1_quo_reg <= quo_prod[QPROD_W-1:16];
            s1_idx_reg <= bin_index;
            s1_re_reg  <= bin_real;
            s1_im_reg  <= bin_imag;
        end
        if (stage_en[ST_IDX])
        begin
            idx_pipe_reg[ST_IDX] <= idx_next;
            re_pipe_reg[ST_IDX]  <= s1_re_reg;
            im_pipe_reg[ST_IDX]  <= s1_im_reg;
        end
        for (int s = ST_IDX + 1; s <= ST_ENV; s++)
        begin
            if (stage_en[s])
            begin
                idx_pipe_reg[s] <= idx_pipe_reg[s - 1];
                re_pipe_reg[s]  <= re_pipe_reg[s - 1];
                im_pipe_reg[s]  <= im_pipe_reg[s - 1];
            end
        end
        if (stage_en[ST_ENV])
        begin
            env_reg <= env_next;
        end
    end

    // Stages 3 to 6: one lane per band, all fed the same reduced index.
    for (genvar l = 0; l < NUM_LANES; l++)
    begin : g_lane
        sbge_band_lane u_lane (
            .clk      (clk),
            .band_cfg (band_cfg[l]),
            .stage_en (stage_en[ST_LANE+3:ST_LANE]),
            .idx      (idx_pipe_reg[ST_IDX]),
            .term     (lane_term[l])
        );
    end

    // Stage 7: base plus band terms, clamped so the envelope is never negative.
    always_comb
    begin
        env_sum = sbge_pkg::ENV_W'($signed({1'b0, base_gain_reg}));
        for (int l = 0; l < NUM_LANES; l++)
        begin
            env_sum = env_sum + sbge_pkg::ENV_W'(lane_term[l]);
        end
        env_next = env_sum[sbge_pkg::ENV_W-1] ? '0 : env_sum[sbge_pkg::ENV_U_W-1:0];
    end

    // Stages 8 and 9: part products, then rounding and saturation.
    sbge_scale #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
        .clk       (clk),
        .stage_en  (stage_en[ST_MUL+1:ST_MUL]),
        .idx       (idx_pipe_reg[ST_ENV]),
        .re        (re_pipe_reg[ST_ENV]),
        .im        (im_pipe_reg[ST_ENV]),
        .env       (env_reg),
        .out_index (out_index),
        .out_real  (out_real),
        .out_imag  (out_imag),
        .clipped   (clipped)
    );

endmodule

// ----- rtl/core/sbge_checker.sv -----
`timescale 1ns / 1ps

module sbge_checker #(
    parameter int HALF_BINS   = 2048,
    parameter int SAMPLE_BITS = 24
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [sbge_pkg::IDX_W-1:0]      out_index,
    input logic signed [SAMPLE_BITS-1:0]   out_real,
    input logic signed [SAMPLE_BITS-1:0]   out_imag,
    input logic                            clipped
);

    localparam logic [SAMPLE_BITS-1:0] SAT_HI = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAT_LO = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    // A result held back by the sink stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_real)
            && $stable(out_imag) && $stable(out_index) && $stable(clipped))
        else $error("result changed while stalled");

    // A clipped result must show a saturated part.
    a_clip_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped |-> (out_real == SAT_HI) || (out_real == SAT_LO)
            || (out_imag == SAT_HI) || (out_imag == SAT_LO))
        else $error("clip flag without a saturated part");

    // The index is reduced into the half spectrum.
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(out_index) < 32'(HALF_BINS)))
        else $error("output index beyond the half spectrum");

    // The pipe is empty right after reset.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result presented straight out of reset");

endmodule

bind spectral_band_gain_equalizer_top sbge_checker #(
    .HALF_BINS   (HALF_BINS),
    .SAMPLE_BITS (SAMPLE_BITS)
) u_sbge_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_index (out_index),
    .out_real  (out_real),
    .out_imag  (out_imag),
    .clipped   (clipped)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int SAMPLE_BITS = 24;

    // Run shape: directed rows first, then random segments of equal length,
    // each segment under a freshly drawn register setup.
    localparam int DIRECTED_COUNT = 23;
    localparam int SEGMENTS       = 12;
    localparam int SEG_ITEMS      = 50;
    localparam int TAIL_CYCLES    = 20;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int MAX_REPORTS    = 10;
    localparam int LUT_SIZE       = 256;

    // Flow-control mixes, in percent of cycles: none, sender gaps,
    // receiver stalls, and both at once.
    localparam int GAP_PCT   [4] = '{0, 48, 0, 32};
    localparam int STALL_PCT [4] = '{0, 0, 48, 32};

    localparam logic signed [SAMPLE_BITS-1:0] MAX_S = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_BITS-1:0] MIN_S = 24'sh800000;
    localparam longint S_HI = 64'sd8388607;
    localparam longint S_LO = -64'sd8388608;

    // One full register image: three band setup words and the base level.
    typedef struct packed {
        logic [sbge_pkg::CFG_DATA_W-1:0] band0;
        logic [sbge_pkg::CFG_DATA_W-1:0] band1;
        logic [sbge_pkg::CFG_DATA_W-1:0] band2;
        logic [sbge_pkg::BASE_W-1:0]     base;
    } eq_setting_t;

    // One equalized bin as it leaves the block.
    typedef struct packed {
        logic [sbge_pkg::IDX_W-1:0]    idx;
        logic signed [SAMPLE_BITS-1:0] re;
        logic signed [SAMPLE_BITS-1:0] im;
        logic                          clip;
    } bin_result_t;

    // One directed row. When typed is set the expected result is given in
    // the row itself; otherwise the predictor supplies it.
    typedef struct packed {
        logic [2:0]                    setup;
        logic [sbge_pkg::IDX_W-1:0]    idx;
        logic signed [SAMPLE_BITS-1:0] re;
        logic signed [SAMPLE_BITS-1:0] im;
        logic                          typed;
        logic signed [SAMPLE_BITS-1:0] want_re;
        logic signed [SAMPLE_BITS-1:0] want_im;
        logic                          want_clip;
    } stim_row_t;

    // Setups referenced by the rows below (built in the main process):
    //   0  reset state, everything zero, so every output is zero
    //   1  unity base level, bands off but with junk in their other fields
    //   2  base level at its largest, above one, so full-scale parts clip
    //   3  unity base, lowpass of most negative gain and highpass of most
    //      positive gain, both at bin 1000; below it the sum goes negative
    //   4  bandpass bands only: one narrow at bin 300, one centered past the
    //      half spectrum with the widest width, one with zero width
    //   5  bandpass whose width puts three bins off center on the last table
    //      entry and four bins off past the table end, plus a lowpass at bin 0
    //      and a highpass at bin 4095 that can never fire
    localparam stim_row_t DIRECTED_TAB [DIRECTED_COUNT] = '{
        '{3'd0, 11'd0,    MAX_S,           MIN_S,           1'b1, 24'sd0, 24'sd0, 1'b0},
        '{3'd0, 11'd2047, -24'sd1,         24'sd1,          1'b1, 24'sd0, 24'sd0, 1'b0},
        '{3'd1, 11'd2047, MAX_S,           MIN_S,           1'b1, MAX_S,  MIN_S,  1'b0},
        '{3'd1, 11'd1,    -24'sd1,         24'sd1,          1'b1, -24'sd1, 24'sd1, 1'b0},
        '{3'd1, 11'd1234, 24'sd5592405,    -24'sd2796202,   1'b1,
          24'sd5592405, -24'sd2796202, 1'b0},
        '{3'd2, 11'd5,    MAX_S,           MIN_S,           1'b1, MAX_S,  MIN_S,  1'b1},
        '{3'd2, 11'd6,    24'sd0,          24'sd0,          1'b1, 24'sd0, 24'sd0, 1'b0},
        '{3'd2, 11'd7,    24'sd1000,       -24'sd1000,      1'b0, 24'sd0, 24'sd0, 1'b0},
        '{3'd3, 11'd0,    MAX_S,           MIN_S,           1'b1, 24'sd0, 24'sd0, 1'b0},
        '{3'd3, 11'd999,  24'sd4321,       -24'sd4321,      1'b1, 24'sd0, 24'sd0, 1'b0},
        '{3'd3, 11'd1000, 24'sd123456,     -24'sd654321,    1'b1,
          24'sd123456, -24'sd654321, 1'b0},
        '{3'd3, 11'd1001, 24'sd1000,       -24'sd1000,      1'b0, 24'sd0, 24'sd0, 1'b0},
        '{3'd3, 11'd2047, MAX_S,           MIN_S,           1'b0, 24'sd0, 24'sd0, 1'b0},
        '{3'd4, 11'd300,  24'sd100000,     -24'sd100000,    1'b0, 24'sd0, 24'sd0, 1'b0},
        '{3'd4, 11'd301,  24'sd2000000,    24'sd77,         1'b0, 24'sd0, 24'sd0, 1'b0},
        '{3'd4, 11'd345,  -24'sd3000000,   24'sd4000000,    1'b0, 24'sd0, 24'sd0, 1'b0},
        '{3'd4, 11'd346,  MAX_S,           MIN_S,           1'b0, 24'sd0, 24'sd0, 1'b0},
        '{3'd4, 11'd2047, 24'sd65536,      -24'sd65536,     1'b0, 24'sd0, 24'sd0, 1'b0},
        '{3'd5, 11'd97,   24'sd1048576,    -24'sd1048576,   1'b0, 24'sd0, 24'sd0, 1'b0},
        '{3'd5, 11'd103,  24'sd999999,     -24'sd5,         1'b0, 24'sd0, 24'sd0, 1'b0},
        '{3'd5, 11'd96,   24'sd1048576,    -24'sd1048576,   1'b0, 24'sd0, 24'sd0, 1'b0},
        '{3'd5, 11'd100,  24'sd1048576,    MIN_S,           1'b0, 24'sd0, 24'sd0, 1'b0},
        '{3'd5, 11'd101,  -24'sd1048576,   24'sd3,          1'b0, 24'sd0, 24'sd0, 1'b0}
    };

    // Block ports. Every input starts at a known value.
    logic                            clk;
    logic                            rst_n     = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [sbge_pkg::CFG_IDX_W-1:0]  cfg_index = sbge_pkg::REG_BAND_ZERO;
    logic [sbge_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                            in_valid  = 1'b0;
    logic                            in_ready;
    logic [sbge_pkg::IDX_W-1:0]      bin_index = '0;
    logic signed [SAMPLE_BITS-1:0]   bin_real  = '0;
    logic signed [SAMPLE_BITS-1:0]   bin_imag  = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [sbge_pkg::IDX_W-1:0]      out_index;
    logic signed [SAMPLE_BITS-1:0]   out_real;
    logic signed [SAMPLE_BITS-1:0]   out_imag;
    logic                            clipped;

    // Testbench copy of the register file; it matches the reset state.
    eq_setting_t live_setup = '0;
    eq_setting_t directed_setups [6];

    // exp(-j/32) in Q0.16, filled at time zero.
    logic [15:0] gauss_lut [LUT_SIZE];

    // Expected equalized bins, oldest first.
    bin_result_t pending_bins [$];

    int src_gap_pct     = 0;
    int sink_stall_pct  = 0;
    int bins_sent       = 0;
    int results_checked = 0;
    int clip_seen       = 0;
    int mismatches      = 0;
    int setups_loaded   = 0;
    int cycle_count     = 0;

    spectral_band_gain_equalizer_top #(
        .HALF_BINS   (2048),
        .BAND_COUNT  (3),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The exp table is built by repeated Q0.32 multiplication with a series
    // value of exp(-1/32), then rounded to Q0.16; the first entry saturates.
    initial
    begin : build_gauss_lut
        longint unsigned term;
        longint unsigned step;
        longint unsigned acc;
        longint unsigned q;
        term = 64'd1 << 32;
        step = term;
        acc  = term;
        for (int n = 1; n <= 10; n++)
        begin
            term = term / (32 * n);
            if (n % 2 == 1)
            begin
                step = step - term;
            end
            else
            begin
                step = step + term;
            end
        end
        for (int i = 0; i < LUT_SIZE; i++)
        begin
            q            = (acc + 64'd32768) >> 16;
            gauss_lut[i] = (q > 64'd65535) ? 16'hFFFF : q[15:0];
            acc          = (acc * step + (64'd1 << 31)) >> 32;
        end
    end

    function automatic logic [sbge_pkg::CFG_DATA_W-1:0] make_band(
        input sbge_pkg::band_mode_t mode,
        input logic [11:0]          pos,
        input logic [17:0]          gain,
        input logic [23:0]          width
    );
        return {width, gain, pos, mode};
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] saturate(input longint v);
        if (v > S_HI)
        begin
            return MAX_S;
        end
        if (v < S_LO)
        begin
            return MIN_S;
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

    // Predicts one equalized bin from the current register copy. The
    // envelope is kept in Q.16 as a wide signed value: base level, plus four
    // times each active step gain, plus each bandpass term gain * E[j]
    // rounded from Q.30 down to Q.16. It is clamped at zero before it scales
    // both parts; arithmetic right shifts give the floor the rounding needs.
    function automatic bin_result_t equalize_bin(
        input logic [sbge_pkg::IDX_W-1:0]    idx,
        input logic signed [SAMPLE_BITS-1:0] re,
        input logic signed [SAMPLE_BITS-1:0] im
    );
        logic [sbge_pkg::CFG_DATA_W-1:0] words [3];
        bin_result_t                     r;
        sbge_pkg::band_mode_t            mode;
        longint                          env;
        longint                          at;
        longint                          pos;
        longint                          gain;
        longint                          k;
        longint                          d;
        longint                          reach;
        longint                          shade;
        longint                          sre;
        longint                          sim;
        words = '{live_setup.band0, live_setup.band1, live_setup.band2};
        // The index port is exactly as wide as the half spectrum, so the
        // modulo reduction never changes it.
        at    = idx;
        env   = live_setup.base;
        for (int b = 0; b < 3; b++)
        begin
            mode = sbge_pkg::band_mode_t'(words[b][1:0]);
            pos  = words[b][13:2];
            gain = $signed(words[b][31:14]);
            k    = words[b][55:32];
            case (mode)
                sbge_pkg::MODE_LOW:
                begin
                    if (at < pos)
                    begin
                        env += 4 * gain;
                    end
                end
                sbge_pkg::MODE_HIGH:
                begin
                    if (at > pos)
                    begin
                        env += 4 * gain;
                    end
                end
                sbge_pkg::MODE_BAND:
                begin
                    d     = (at > pos) ? at - pos : pos - at;
                    reach = (d * d * k) >>> 19;
                    if (reach < LUT_SIZE)
                    begin
                        shade = gauss_lut[reach];
                        env += (gain * shade + 8192) >>> 14;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (env < 0)
        begin
            env = 0;
        end
        sre    = (re * env + 32768) >>> 16;
        sim    = (im * env + 32768) >>> 16;
        r.idx  = idx;
        r.re   = saturate(sre);
        r.im   = saturate(sim);
        r.clip = (sre > S_HI) || (sre < S_LO) || (sim > S_HI) || (sim < S_LO);
        return r;
    endfunction

    // Random band word. Positions are mostly inside the half spectrum;
    // gains are spread over magnitudes with both extremes; the width mask
    // length is random so that bandpass terms land anywhere in the table,
    // past its end, or at zero width.
    function automatic logic [sbge_pkg::CFG_DATA_W-1:0] random_band();
        logic [11:0] pos;
        logic [17:0] gain;
        logic [23:0] width;
        logic [31:0] raw;
        if ($urandom_range(0, 7) == 0)
        begin
            pos = 12'($urandom_range(2048, 4095));
        end
        else
        begin
            pos = 12'($urandom_range(0, 2047));
        end
        raw = $urandom;
        case ($urandom_range(0, 7))
            0:       gain = 18'h1FFFF;
            1:       gain = 18'h20000;
            default: gain = 18'($signed(raw[17:0]) >>> $urandom_range(0, 12));
        endcase
        width = 24'($urandom) & 24'((32'd1 << $urandom_range(0, 24)) - 32'd1);
        return make_band(sbge_pkg::band_mode_t'($urandom_range(0, 3)), pos, gain, width);
    endfunction

    // Random part value: mostly random magnitudes, sometimes an extreme.
    function automatic logic signed [SAMPLE_BITS-1:0] random_part();
        case ($urandom_range(0, 9))
            0:       return MAX_S;
            1:       return MIN_S;
            2:       return 24'sd0;
            3:       return -24'sd1;
            default: return $signed(24'($urandom)) >>> $urandom_range(0, 23);
        endcase
    endfunction

    function automatic void flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("%s", msg);
        end
    endfunction

    // Offers one bin, holding valid and payload until the transaction is
    // taken, and queues its expected result at that edge. Idle gaps come
    // before the offer, so valid never depends on ready.
    task automatic feed_bin(
        input logic [sbge_pkg::IDX_W-1:0]    idx,
        input logic signed [SAMPLE_BITS-1:0] re,
        input logic signed [SAMPLE_BITS-1:0] im,
        input bin_result_t                   want
    );
        while ($urandom_range(0, 99) < src_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        bin_index <= idx;
        bin_real  <= re;
        bin_imag  <= im;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        pending_bins.push_back(want);
        bins_sent++;
    endtask

    // Every bin yields exactly one result, so the pipe is empty once the
    // last expected result has been taken.
    task automatic quiesce();
        in_valid <= 1'b0;
        while (pending_bins.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Writes all four registers, one per cycle, and mirrors them.
    task automatic load_setting(input eq_setting_t s);
        cfg_we    <= 1'b1;
        cfg_index <= sbge_pkg::REG_BAND_ZERO;
        cfg_data  <= s.band0;
        @(posedge clk);
        cfg_index <= sbge_pkg::REG_BAND_ONE;
        cfg_data  <= s.band1;
        @(posedge clk);
        cfg_index <= sbge_pkg::REG_BAND_TWO;
        cfg_data  <= s.band2;
        @(posedge clk);
        cfg_index <= sbge_pkg::REG_BASE_GAIN;
        cfg_data  <= sbge_pkg::CFG_DATA_W'(s.base);
        @(posedge clk);
        cfg_we     <= 1'b0;
        live_setup = s;
        setups_loaded++;
    endtask

    // The receiver drops ready at random with the current stall rate.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Each result transaction is compared field by field with the oldest
    // expectation; one with nothing waiting is an error as well.
    always @(posedge clk)
    begin : check_results
        bin_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_bins.size() == 0)
            begin
                flag_mismatch($sformatf(
                    "unexpected result: idx %0d re %0d im %0d clip %0d",
                    out_index, out_real, out_imag, clipped));
            end
            else
            begin
                want = pending_bins.pop_front();
                if (out_index !== want.idx || out_real !== want.re ||
                    out_imag !== want.im || clipped !== want.clip)
                begin
                    flag_mismatch($sformatf(
                        {"result %0d: expected idx %0d re %0d im %0d clip %0d, ",
                         "got idx %0d re %0d im %0d clip %0d"},
                        results_checked, want.idx, want.re, want.im, want.clip,
                        out_index, out_real, out_imag, clipped));
                end
            end
            if (clipped === 1'b1)
            begin
                clip_seen++;
            end
            results_checked++;
        end
    end

    // Watchdog: a run that reaches CYCLE_LIMIT is ended and reported as failing.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still expected.",
                     cycle_count, pending_bins.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin : main_sequence
        stim_row_t                     row;
        bin_result_t                   want;
        eq_setting_t                   fresh;
        logic [sbge_pkg::IDX_W-1:0]    idx;
        logic signed [SAMPLE_BITS-1:0] re;
        logic signed [SAMPLE_BITS-1:0] im;
        int                            cur_setup;
        int                            center;

        directed_setups[0] = '{'0, '0, '0, '0};
        directed_setups[1] = '{
            make_band(sbge_pkg::MODE_NONE, 12'd5, 18'h1FFFF, 24'hFFFFFF),
            make_band(sbge_pkg::MODE_NONE, 12'd4095, 18'h20000, 24'h123456),
            '0,
            17'd65536};
        directed_setups[2] = '{'0, '0, '0, 17'h1FFFF};
        directed_setups[3] = '{
            make_band(sbge_pkg::MODE_LOW, 12'd1000, 18'h20000, 24'd0),
            make_band(sbge_pkg::MODE_HIGH, 12'd1000, 18'h1FFFF, 24'hFFFFFF),
            '0,
            17'd65536};
        directed_setups[4] = '{
            make_band(sbge_pkg::MODE_BAND, 12'd300, 18'h1FFFF, 24'h010000),
            make_band(sbge_pkg::MODE_BAND, 12'd4095, 18'h20000, 24'hFFFFFF),
            make_band(sbge_pkg::MODE_BAND, 12'd2047, 18'h10000, 24'd0),
            17'd0};
        directed_setups[5] = '{
            make_band(sbge_pkg::MODE_BAND, 12'd100, 18'h1FFFF, 24'd14854827),
            make_band(sbge_pkg::MODE_LOW, 12'd0, 18'h1FFFF, 24'd0),
            make_band(sbge_pkg::MODE_HIGH, 12'd4095, 18'h1FFFF, 24'd0),
            17'd65536};

        // Reset is held from time zero and released on a clock edge.
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows, with no idling on either side. The first rows run
        // on the reset values before any register is written.
        cur_setup = 0;
        for (int r = 0; r < DIRECTED_COUNT; r++)
        begin
            row = DIRECTED_TAB[r];
            if (int'(row.setup) != cur_setup)
            begin
                quiesce();
                load_setting(directed_setups[row.setup]);
                cur_setup = row.setup;
            end
            if (row.typed)
            begin
                want = '{row.idx, row.want_re, row.want_im, row.want_clip};
            end
            else
            begin
                want = equalize_bin(row.idx, row.re, row.im);
            end
            feed_bin(row.idx, row.re, row.im, want);
        end

        // Random segments. Each one loads a new random setup once the pipe
        // has drained and runs under one of the four flow-control mixes.
        // Half of the bins fall within forty bins of some band position, so
        // that step edges and the table region of bandpass bands are hit.
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            quiesce();
            fresh.band0 = random_band();
            fresh.band1 = random_band();
            fresh.band2 = random_band();
            case ($urandom_range(0, 5))
                0:       fresh.base = '0;
                1:       fresh.base = 17'd65536;
                2:       fresh.base = 17'h1FFFF;
                default: fresh.base = 17'($urandom_range(0, 131071));
            endcase
            load_setting(fresh);
            src_gap_pct    = GAP_PCT[seg % 4];
            sink_stall_pct = STALL_PCT[seg % 4];
            for (int n = 0; n < SEG_ITEMS; n++)
            begin
                case ($urandom_range(0, 2))
                    0:       center = live_setup.band0[13:2];
                    1:       center = live_setup.band1[13:2];
                    default: center = live_setup.band2[13:2];
                endcase
                if ($urandom_range(0, 1) == 1)
                begin
                    idx = sbge_pkg::IDX_W'(center + int'($urandom_range(0, 80)) - 40);
                end
                else
                begin
                    idx = sbge_pkg::IDX_W'($urandom_range(0, 2047));
                end
                re = random_part();
                im = random_part();
                feed_bin(idx, re, im, equalize_bin(idx, re, im));
            end
        end

        // Let the last results out, then watch a little longer for strays.
        quiesce();
        sink_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d bins under %0d register setups and four flow-control mixes.",
                 bins_sent, setups_loaded);
        $display("Checked %0d results, %0d of them saturated, %0d mismatching.",
                 results_checked, clip_seen, mismatches);
        if (mismatches == 0 && pending_bins.size() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/sbge_pkg.sv
rtl/core/sbge_band_lane.sv
rtl/core/sbge_scale.sv
rtl/core/spectral_band_gain_equalizer_top.sv
rtl/core/sbge_checker.sv
tb/tb.sv
